// ===== hdl/tpps_pkg.sv =====
// Shared constants, register indexes and table functions for the torus point projector.
package tpps_pkg;

    typedef enum logic [2:0] {
        REG_X_ROT   = 3'd0,
        REG_Z_ROT   = 3'd1,
        REG_MAJOR   = 3'd2,
        REG_MINOR   = 3'd3,
        REG_VIEWER  = 3'd4
    } t_cfg_index;

    localparam int CW    = 14;   // coordinate width, Q6.8 signed
    localparam int TW    = 16;   // Q2.14 trig width, signed
    localparam int NW    = 24;   // divide numerator width, signed
    localparam int RW    = 24;   // divider remainder width
    localparam int QW    = 8;    // quotient bits (screen up to 256 cells)
    localparam int VW    = 17;   // brightness dot product width, signed
    localparam int BW    = 38;   // scaled squared brightness width
    localparam int RAMP_TOP = 11;

    // Quarter-wave sine magnitude in Q14 from a 16-bit phase fraction.
    // Evaluated at elaboration only.
    function automatic logic [14:0] sine_poly(input longint unsigned f);
        longint unsigned x, x2, t, s, q;
        x  = f << 16;
        x2 = (x * x) >> 30;
        t  = 64'd172272;
        t  = 64'd5026995    - ((x2 * t) >> 30);
        t  = 64'd85569306   - ((x2 * t) >> 30);
        t  = 64'd693598669  - ((x2 * t) >> 30);
        t  = 64'd1686629713 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        q  = (s + 64'd32768) >> 16;
        if (q > 64'd16384) begin
            q = 64'd16384;
        end
        return q[14:0];
    endfunction

    // Brightness ramp ".,-~:;=!*#$@"
    function automatic logic [6:0] ramp_char(input logic [3:0] k);
        logic [6:0] c;
        case (k)
            4'd0:    c = 7'h2E;
            4'd1:    c = 7'h2C;
            4'd2:    c = 7'h2D;
            4'd3:    c = 7'h7E;
            4'd4:    c = 7'h3A;
            4'd5:    c = 7'h3B;
            4'd6:    c = 7'h3D;
            4'd7:    c = 7'h21;
            4'd8:    c = 7'h2A;
            4'd9:    c = 7'h23;
            4'd10:   c = 7'h24;
            default: c = 7'h40;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/torus_point_project_shade.sv =====
// Top level: pipelined torus point build, rotate, project and shade.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, tube/ring phase   | beat in
//  out     | o_out_valid, i_out_stall, col/row/vis/gly | beat out
//  cfg     | i_cfg_valid, o_cfg_ready, index, data     | write in
//
// Twelve register stages; one beat enters per cycle while the input is not stalled.
// Stages: trig lookup, tube radius, ring point, X rotation, Z rotation,
// numerators, range check, four radix-4 divider stages, output register.
// Reset is synchronous active low; it clears valid bits and loads config registers with defaults.
// A stage holds when it is full and the one after it holds; bubbles fill,
// so only a full pipe backs the stall up to the input.
module torus_point_project_shade
    import tpps_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 22,
    parameter int ANGLE_BITS     = 10
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  logic [ANGLE_BITS-1:0]                         i_tube_phase,
    input  logic [ANGLE_BITS-1:0]                         i_ring_phase,
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output logic [(SCREEN_COLUMNS > 1 ? $clog2(SCREEN_COLUMNS) : 1)-1:0] o_column,
    output logic [(SCREEN_ROWS > 1 ? $clog2(SCREEN_ROWS) : 1)-1:0]       o_row,
    output logic                                          o_visible,
    output logic [6:0]                                    o_glyph,
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [2:0]                                    i_cfg_index,
    input  logic [11:0]                                   i_cfg_data
);

    localparam int CLW = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
    localparam int ROW_W = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int QD  = 1 << (ANGLE_BITS - 2);   // quarter turn in phase steps
    localparam int NST = 12;

    // ---------------- configuration registers ----------------
    logic [9:0]  r_xrot, r_zrot, r_major, r_minor;
    logic [11:0] r_vdist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xrot  <= '0;
            r_zrot  <= '0;
            r_major <= 10'd512;
            r_minor <= 10'd256;
            r_vdist <= 12'd1280;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_X_ROT:  r_xrot  <= i_cfg_data[9:0];
                REG_Z_ROT:  r_zrot  <= i_cfg_data[9:0];
                REG_MAJOR:  r_major <= i_cfg_data[9:0];
                REG_MINOR:  r_minor <= i_cfg_data[9:0];
                REG_VIEWER: r_vdist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage flow control ----------------
    logic [NST:1]   r_v;
    logic [NST+1:1] w_en;

    assign w_en[NST+1] = !i_out_stall;
    genvar gs;
    generate
        for (gs = 1; gs <= NST; gs++) begin : g_en
            assign w_en[gs] = !r_v[gs] || w_en[gs+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_in_valid;
            for (int s = 2; s <= NST; s++) begin
                if (w_en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    assign o_in_stall  = !w_en[1];
    assign o_out_valid = r_v[NST];

    // ---------------- quarter-wave sine table ----------------
    logic [14:0] w_rom [QD+1];
    genvar gj;
    generate
        for (gj = 0; gj <= QD; gj++) begin : g_rom
            assign w_rom[gj] = sine_poly(longint'(gj) << (16 - ANGLE_BITS));
        end
    endgenerate

    // Eight lookups: tube sin/cos, ring sin/cos, X rot sin/cos, Z rot sin/cos
    logic [ANGLE_BITS-1:0] w_ph   [8];
    logic signed [TW-1:0]  w_trig [8];

    assign w_ph[0] = i_tube_phase;
    assign w_ph[1] = i_tube_phase + ANGLE_BITS'(QD);
    assign w_ph[2] = i_ring_phase;
    assign w_ph[3] = i_ring_phase + ANGLE_BITS'(QD);
    assign w_ph[4] = ANGLE_BITS'(r_xrot);
    assign w_ph[5] = ANGLE_BITS'(r_xrot) + ANGLE_BITS'(QD);
    assign w_ph[6] = ANGLE_BITS'(r_zrot);
    assign w_ph[7] = ANGLE_BITS'(r_zrot) + ANGLE_BITS'(QD);

    genvar gl;
    generate
        for (gl = 0; gl < 8; gl++) begin : g_lut
            logic [1:0]            quad;
            logic [ANGLE_BITS-2:0] idx;
            logic signed [TW-1:0]  mag;
            always_comb begin
                quad = w_ph[gl][ANGLE_BITS-1:ANGLE_BITS-2];
                idx  = {1'b0, w_ph[gl][ANGLE_BITS-3:0]};
                if (quad[0]) idx = (ANGLE_BITS-1)'(QD) - idx;
                mag  = $signed(TW'(w_rom[idx]));
                w_trig[gl] = quad[1] ? -mag : mag;
            end
        end
    endgenerate

    // Rotation trig follows configuration, which the user must change only while idle; the block does not enforce it.
    logic signed [TW-1:0] r_sa, r_ca, r_sb, r_cb;
    always_ff @(posedge i_clk) begin
        r_sa <= w_trig[4];
        r_ca <= w_trig[5];
        r_sb <= w_trig[6];
        r_cb <= w_trig[7];
    end

    // ---------------- stage 1: point trig ----------------
    logic signed [TW-1:0] r1_st, r1_ct, r1_sp, r1_cp;
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_st <= w_trig[0];
            r1_ct <= w_trig[1];
            r1_sp <= w_trig[2];
            r1_cp <= w_trig[3];
        end
    end

    // ---------------- stage 2: tube offset ----------------
    logic signed [26:0]   w2_rct, w2_rst;
    logic signed [31:0]   w2_ctsp;
    logic signed [CW-1:0] r2_ring, r2_z;
    logic signed [TW-1:0] r2_sp, r2_cp, r2_st, r2_ctsp;

    assign w2_rct  = $signed({1'b0, r_minor}) * r1_ct;
    assign w2_rst  = $signed({1'b0, r_minor}) * r1_st;
    assign w2_ctsp = r1_ct * r1_sp;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_ring <= CW'(w2_rct >>> 14) + $signed(CW'(r_major));
            r2_z    <= CW'(w2_rst >>> 14);
            r2_ctsp <= TW'(w2_ctsp >>> 14);
            r2_sp   <= r1_sp;
            r2_cp   <= r1_cp;
            r2_st   <= r1_st;
        end
    end

    // ---------------- stage 3: ring point ----------------
    logic signed [29:0]   w3_x, w3_y;
    logic signed [CW-1:0] r3_x, r3_y, r3_z;
    logic signed [VW-1:0] r3_v;

    assign w3_x = r2_ring * r2_cp;
    assign w3_y = r2_ring * r2_sp;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_x <= CW'(w3_x >>> 14);
            r3_y <= CW'(w3_y >>> 14);
            r3_z <= r2_z;
            r3_v <= VW'(r2_ctsp) - VW'(r2_st);
        end
    end

    // ---------------- stage 4: rotate about X ----------------
    logic signed [30:0]   w4_y1, w4_z1;
    logic signed [CW-1:0] r4_x, r4_y1, r4_z1;
    logic [30:0]          r4_vsq;
    logic                 r4_vpos;
    logic signed [33:0]   w4_vsq;

    assign w4_y1  = 31'(r3_y) * 31'(r_ca) - 31'(r3_z) * 31'(r_sa);
    assign w4_z1  = 31'(r3_y) * 31'(r_sa) + 31'(r3_z) * 31'(r_ca);
    assign w4_vsq = r3_v * r3_v;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_x    <= r3_x;
            r4_y1   <= CW'(w4_y1 >>> 14);
            r4_z1   <= CW'(w4_z1 >>> 14);
            r4_vsq  <= 31'(w4_vsq);
            r4_vpos <= (r3_v > 0);
        end
    end

    // ---------------- stage 5: rotate about Z, depth ----------------
    logic signed [30:0]   w5_x2, w5_y2;
    logic signed [CW-1:0] r5_x2, r5_y2, r5_d;
    logic [BW-1:0]        r5_v121;
    logic                 r5_vpos;

    assign w5_x2 = 31'(r4_x) * 31'(r_cb) - 31'(r4_y1) * 31'(r_sb);
    assign w5_y2 = 31'(r4_x) * 31'(r_sb) + 31'(r4_y1) * 31'(r_cb);

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_x2   <= CW'(w5_x2 >>> 14);
            r5_y2   <= CW'(w5_y2 >>> 14);
            r5_d    <= r4_z1 + $signed(CW'(r_vdist));
            r5_v121 <= BW'(r4_vsq) * BW'(121);
            r5_vpos <= r4_vpos;
        end
    end

    // ---------------- stage 6: numerators, brightness step ----------------
    logic signed [NW-1:0] r6_nc, r6_nr, r6_d;
    logic [3:0]           r6_k, w6_k;

    always_comb begin
        w6_k = '0;
        for (int m = 1; m <= RAMP_TOP; m++) begin
            if (r5_v121 >= (BW'(m * m) << 29)) w6_k = w6_k + 4'd1;
        end
        if (!r5_vpos) w6_k = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_nc <= NW'(r5_x2) * NW'(30) + NW'(r5_d) * NW'(40);
            r6_nr <= NW'(r5_y2) * NW'(15) + NW'(r5_d) * NW'(12);
            r6_d  <= NW'(r5_d);
            r6_k  <= w6_k;
        end
    end

    // ---------------- stage 7: range check, divider setup ----------------
    // Truncation toward zero keeps a cell index of zero for -d < n < 0.
    logic signed [NW+9:0] w7_clim, w7_rlim;
    logic                 w7_vis;

    assign w7_clim = (NW+10)'(r6_d) * (NW+10)'(SCREEN_COLUMNS);
    assign w7_rlim = (NW+10)'(r6_d) * (NW+10)'(SCREEN_ROWS);
    assign w7_vis  = (r6_d > 0)
                   && (r6_nc > -r6_d) && ((NW+10)'(r6_nc) < w7_clim)
                   && (r6_nr > -r6_d) && ((NW+10)'(r6_nr) < w7_rlim);

    logic [RW-1:0] r_crem [5];
    logic [RW-1:0] r_rrem [5];
    logic [QW-1:0] r_cq   [5];
    logic [QW-1:0] r_rq   [5];
    logic [RW-1:0] r_dd   [5];
    logic [3:0]    r_kk   [5];
    logic          r_vis  [5];

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_crem[0] <= (r6_nc < 0) ? '0 : RW'(r6_nc);
            r_rrem[0] <= (r6_nr < 0) ? '0 : RW'(r6_nr);
            r_cq[0]   <= '0;
            r_rq[0]   <= '0;
            r_dd[0]   <= RW'(r6_d);
            r_kk[0]   <= r6_k;
            r_vis[0]  <= w7_vis;
        end
    end

    // ---------------- stages 8-11: restoring divide, two bits a stage ----------------
    genvar gd;
    generate
        for (gd = 0; gd < 4; gd++) begin : g_div
            localparam int B_HI = QW - 1 - 2 * gd;
            logic [RW-1:0] crem1, rrem1, crem2, rrem2;
            logic          cb1, rb1, cb0, rb0;
            always_comb begin
                cb1   = r_crem[gd] >= (r_dd[gd] << B_HI);
                crem1 = cb1 ? r_crem[gd] - (r_dd[gd] << B_HI) : r_crem[gd];
                cb0   = crem1 >= (r_dd[gd] << (B_HI - 1));
                crem2 = cb0 ? crem1 - (r_dd[gd] << (B_HI - 1)) : crem1;
                rb1   = r_rrem[gd] >= (r_dd[gd] << B_HI);
                rrem1 = rb1 ? r_rrem[gd] - (r_dd[gd] << B_HI) : r_rrem[gd];
                rb0   = rrem1 >= (r_dd[gd] << (B_HI - 1));
                rrem2 = rb0 ? rrem1 - (r_dd[gd] << (B_HI - 1)) : rrem1;
            end
            always_ff @(posedge i_clk) begin
                if (w_en[8+gd]) begin
                    r_crem[gd+1] <= crem2;
                    r_rrem[gd+1] <= rrem2;
                    r_cq[gd+1]   <= r_cq[gd] | (QW'({cb1, cb0}) << (B_HI - 1));
                    r_rq[gd+1]   <= r_rq[gd] | (QW'({rb1, rb0}) << (B_HI - 1));
                    r_dd[gd+1]   <= r_dd[gd];
                    r_kk[gd+1]   <= r_kk[gd];
                    r_vis[gd+1]  <= r_vis[gd];
                end
            end
        end
    endgenerate

    // ---------------- stage 12: output register ----------------
    always_ff @(posedge i_clk) begin
        if (w_en[12]) begin
            o_visible <= r_vis[4];
            o_column  <= r_vis[4] ? CLW'(r_cq[4]) : '0;
            o_row     <= r_vis[4] ? ROW_W'(r_rq[4]) : '0;
            o_glyph   <= r_vis[4] ? ramp_char(r_kk[4]) : '0;
        end
    end

    // ---------------- assertions ----------------
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_visible) |-> (o_column == '0 && o_row == '0 && o_glyph == '0))
        else $error("hidden point carries nonzero fields");

    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_visible) |->
            (32'(o_column) < SCREEN_COLUMNS && 32'(o_row) < SCREEN_ROWS && o_glyph != '0))
        else $error("visible point off screen or without glyph");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with room in the pipe");

endmodule
